@@ hdl/gic_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gic_pkg
// Shared types and constants of the gamepad input conditioner.
// ----------------------------------------------------------------------------
package gic_pkg;

    localparam int BTN_COUNT = 32;
    localparam logic [31:0] BTN_MASK =
        (BTN_COUNT >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << BTN_COUNT) - 64'd1);

    localparam logic [6:0] DZ_RESET = 7'd20;
    localparam logic [6:0] FS_RESET = 7'd100;

    localparam logic CFG_DEAD_ZONE  = 1'b0;
    localparam logic CFG_FULL_SCALE = 1'b1;

    localparam logic [1:0] EDGE_NONE     = 2'd0;
    localparam logic [1:0] EDGE_PRESSED  = 2'd1;
    localparam logic [1:0] EDGE_RELEASED = 2'd2;
    localparam logic [1:0] EDGE_HELD     = 2'd3;

    typedef struct packed {
        logic               link_up;
        logic signed [15:0] left_axis_x;
        logic signed [15:0] left_axis_y;
        logic signed [15:0] right_axis_x;
        logic signed [15:0] right_axis_y;
        logic signed [15:0] trigger_axis;
        logic [31:0]        button_bits;
        logic [4:0]         button_index;
    } t_in;

    typedef struct packed {
        logic signed [15:0] left_out_x;
        logic signed [15:0] left_out_y;
        logic signed [15:0] right_out_x;
        logic signed [15:0] right_out_y;
        logic [14:0]        left_pull;
        logic [14:0]        right_pull;
        logic               is_connected;
        logic [1:0]         edge_state;
    } t_out;

    typedef struct packed {
        logic left_busy;
        logic right_busy;
        logic trig_busy;
    } t_lane_status;

endpackage

@@ hdl/gamepad_input_conditioner_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_input_conditioner_unit
// Per-poll dead-zone conditioning of two sticks and a trigger, button edges.
// ----------------------------------------------------------------------------
// One poll is processed at a time. On the longest path the result register is
// loaded after the stick lanes finish: a 16-step square root followed by a
// 15-step restoring divide. A poll whose sticks sit inside the dead zone skips
// both, and finishes sooner still when the trigger needs no divide. The input
// stalls until the result is loaded, so a new poll is taken only after the
// last one is through, and a stalled output holds back the result load. Both
// sticks and the trigger run in their own lanes side by side; the top level
// merges their results with the held state. A new poll may be transferred in
// while the previous result still waits at the output register.
module gamepad_input_conditioner_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  gic_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output gic_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [6:0]    i_cfg_data
);
    import gic_pkg::*;

    logic [6:0]  r_dz, r_fs;
    logic [31:0] r_curr;
    logic [15:0] r_lx, r_ly, r_rx, r_ry;
    logic [14:0] r_lpull, r_rpull;
    logic        r_link, r_run, r_out_valid;
    logic [1:0]  r_edge;
    t_out        r_out;

    t_lane_status st;
    logic [15:0]  lx, ly, rx, ry;
    logic         tpos;
    logic [14:0]  tlvl;
    logic         accept, finish;
    logic [31:0]  n_curr;
    logic [1:0]   n_edge;
    logic [15:0]  n_lx, n_ly, n_rx, n_ry;
    logic [14:0]  n_lpull, n_rpull;
    logic         pc, cc;

    assign accept = i_in_valid && !r_run;
    assign finish = r_run && !st.left_busy && !st.right_busy && !st.trig_busy
                    && (!r_out_valid || !i_out_stall);

    gic_stick_lane u_left (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(accept),
        .i_x(i_in_data.left_axis_x), .i_y(i_in_data.left_axis_y),
        .i_dz(r_dz), .i_fs(r_fs), .o_busy(st.left_busy),
        .o_out_x(lx), .o_out_y(ly)
    );

    gic_stick_lane u_right (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(accept),
        .i_x(i_in_data.right_axis_x), .i_y(i_in_data.right_axis_y),
        .i_dz(r_dz), .i_fs(r_fs), .o_busy(st.right_busy),
        .o_out_x(rx), .o_out_y(ry)
    );

    gic_trigger_lane u_trig (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(accept),
        .i_t(i_in_data.trigger_axis), .i_dz(r_dz), .i_fs(r_fs),
        .o_busy(st.trig_busy), .o_pos(tpos), .o_level(tlvl)
    );

    // Button edges are known at transfer time from the stored previous button bits.
    always_comb begin
        n_curr = i_in_data.link_up ? (i_in_data.button_bits & BTN_MASK) : r_curr;
        pc     = r_curr[i_in_data.button_index];
        cc     = n_curr[i_in_data.button_index];
        if ({27'd0, i_in_data.button_index} >= 32'(BTN_COUNT)) n_edge = EDGE_NONE;
        else if (pc && cc)  n_edge = EDGE_HELD;
        else if (pc)        n_edge = EDGE_RELEASED;
        else if (cc)        n_edge = EDGE_PRESSED;
        else                n_edge = EDGE_NONE;
    end

    always_comb begin
        n_lx    = r_link ? lx : r_lx;
        n_ly    = r_link ? ly : r_ly;
        n_rx    = r_link ? rx : r_rx;
        n_ry    = r_link ? ry : r_ry;
        n_lpull = r_lpull;
        n_rpull = r_rpull;
        if (r_link) begin
            if (tpos && tlvl != 15'd0) n_lpull = tlvl;
            else                      n_rpull = tlvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz <= DZ_RESET;
            r_fs <= FS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEAD_ZONE:  r_dz <= i_cfg_data;
                CFG_FULL_SCALE: r_fs <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curr      <= '0;
            r_lx        <= '0;
            r_ly        <= '0;
            r_rx        <= '0;
            r_ry        <= '0;
            r_lpull     <= '0;
            r_rpull     <= '0;
            r_link      <= 1'b0;
            r_edge      <= EDGE_NONE;
            r_run       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_curr <= n_curr;
                r_link <= i_in_data.link_up;
                r_edge <= n_edge;
                r_run  <= 1'b1;
            end
            if (finish) begin
                r_lx        <= n_lx;
                r_ly        <= n_ly;
                r_rx        <= n_rx;
                r_ry        <= n_ry;
                r_lpull     <= n_lpull;
                r_rpull     <= n_rpull;
                r_run       <= 1'b0;
                r_out_valid <= 1'b1;
                r_out       <= '{left_out_x: n_lx, left_out_y: n_ly,
                                 right_out_x: n_rx, right_out_y: n_ry,
                                 left_pull: n_lpull, right_pull: n_rpull,
                                 is_connected: r_link, edge_state: r_edge};
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = r_run;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_idle_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_run |-> !(st.left_busy || st.right_busy || st.trig_busy))
        else $error("lane busy while no poll is in flight");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_run && st.left_busy && st.right_busy && st.trig_busy))
        else $error("lanes did not start on an input transfer");

    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (o_out_valid && !r_run))
        else $error("finished poll did not reach the output register");

endmodule

@@ hdl/gic_stick_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gic_stick_lane
// Scaled radial dead zone of one stick: square sum, bit-pair square root,
// three multiplies and two restoring dividers running in parallel.
// ----------------------------------------------------------------------------
module gic_stick_lane (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_x,
    input  logic [15:0] i_y,
    input  logic [6:0]  i_dz,
    input  logic [6:0]  i_fs,
    output logic        o_busy,
    output logic [15:0] o_out_x,
    output logic [15:0] o_out_y
);
    import gic_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_SQRT = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_DSET = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]  r_state;
    logic [3:0]  r_cnt;
    logic [15:0] r_ax, r_ay;
    logic        r_nx, r_ny;
    logic [31:0] r_sq, r_res, r_bit;
    logic [30:0] r_px, r_py, r_den;
    logic [44:0] r_rx, r_ry, r_dsh;
    logic [14:0] r_qx, r_qy;
    logic [15:0] r_ox, r_oy;

    logic [13:0] dz_sq;
    logic [31:0] trial;
    logic [15:0] len, diff;
    logic [14:0] span, dzs, m, spanv;
    logic        fs_above;
    logic        gex, gey;

    assign dz_sq    = 14'(i_dz * i_dz);
    assign trial    = r_res + r_bit;
    assign len      = r_res[15:0];
    assign fs_above = i_fs > i_dz;
    assign span     = {i_fs - i_dz, 8'd0};
    assign dzs      = {i_dz, 8'd0};
    assign diff     = len - {1'b0, dzs};
    assign m        = fs_above ? ((diff > {1'b0, span}) ? span : diff[14:0]) : 15'd1;
    assign spanv    = fs_above ? span : 15'd1;
    assign gex      = r_rx >= r_dsh;
    assign gey      = r_ry >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ox    <= '0;
            r_oy    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_nx    <= i_x[15];
                        r_ny    <= i_y[15];
                        r_ax    <= i_x[15] ? (~i_x + 16'd1) : i_x;
                        r_ay    <= i_y[15] ? (~i_y + 16'd1) : i_y;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_sq    <= 32'(r_ax * r_ax) + 32'(r_ay * r_ay);
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_sq < {2'b00, dz_sq, 16'd0}) begin
                        r_ox    <= '0;
                        r_oy    <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_res   <= '0;
                        r_bit   <= 32'h4000_0000;
                        r_cnt   <= 4'd15;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_sq >= trial) begin
                        r_sq  <= r_sq - trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt - 4'd1;
                    if (r_cnt == 4'd0) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (len == 16'd0) begin
                        r_ox    <= '0;
                        r_oy    <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_px    <= 31'(r_ax * m);
                        r_py    <= 31'(r_ay * m);
                        r_den   <= 31'(spanv * len);
                        r_state <= S_DSET;
                    end
                end
                S_DSET: begin
                    r_rx    <= {r_px, 14'd0};
                    r_ry    <= {r_py, 14'd0};
                    r_dsh   <= {r_den, 14'd0};
                    r_cnt   <= 4'd14;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // Quotient never exceeds 16384, so fifteen bits suffice.
                    if (gex) r_rx <= r_rx - r_dsh;
                    if (gey) r_ry <= r_ry - r_dsh;
                    r_qx  <= {r_qx[13:0], gex};
                    r_qy  <= {r_qy[13:0], gey};
                    r_dsh <= r_dsh >> 1;
                    r_cnt <= r_cnt - 4'd1;
                    if (r_cnt == 4'd0) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_ox    <= r_nx ? (16'd0 - {1'b0, r_qx}) : {1'b0, r_qx};
                    r_oy    <= r_ny ? (16'd0 - {1'b0, r_qy}) : {1'b0, r_qy};
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy  = r_state != S_IDLE;
    assign o_out_x = r_ox;
    assign o_out_y = r_oy;

endmodule

@@ hdl/gic_trigger_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gic_trigger_lane
// Linear dead zone of the trigger axis with a restoring divider.
// ----------------------------------------------------------------------------
module gic_trigger_lane (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_t,
    input  logic [6:0]  i_dz,
    input  logic [6:0]  i_fs,
    output logic        o_busy,
    output logic        o_pos,
    output logic [14:0] o_level
);
    import gic_pkg::*;

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_CALC = 2'd1;
    localparam logic [1:0] T_DIV  = 2'd2;
    localparam logic [1:0] T_OUT  = 2'd3;

    logic [1:0]  r_state;
    logic [3:0]  r_cnt;
    logic [7:0]  r_a;
    logic        r_pos;
    logic [20:0] r_rem, r_dsh;
    logic [14:0] r_q, r_level;

    logic [15:0] mag;
    logic [6:0]  span;
    logic [7:0]  diff, m;
    logic        ge;

    assign mag  = i_t[15] ? (~i_t + 16'd1) : i_t;
    assign span = i_fs - i_dz;
    assign diff = r_a - {1'b0, i_dz};
    assign m    = (diff > {1'b0, span}) ? {1'b0, span} : diff;
    assign ge   = r_rem >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_level <= '0;
            r_pos   <= 1'b0;
        end else begin
            case (r_state)
                T_IDLE: begin
                    if (i_start) begin
                        r_a     <= mag[15:8];
                        r_pos   <= !i_t[15] && (i_t != 16'd0);
                        r_state <= T_CALC;
                    end
                end
                T_CALC: begin
                    if (r_a <= {1'b0, i_dz}) begin
                        r_level <= '0;
                        r_state <= T_IDLE;
                    end else if (i_fs <= i_dz) begin
                        r_level <= 15'd16384;
                        r_state <= T_IDLE;
                    end else begin
                        r_rem   <= {m[6:0], 14'd0};
                        r_dsh   <= {span, 14'd0};
                        r_cnt   <= 4'd14;
                        r_state <= T_DIV;
                    end
                end
                T_DIV: begin
                    if (ge) r_rem <= r_rem - r_dsh;
                    r_q   <= {r_q[13:0], ge};
                    r_dsh <= r_dsh >> 1;
                    r_cnt <= r_cnt - 4'd1;
                    if (r_cnt == 4'd0) begin
                        r_state <= T_OUT;
                    end
                end
                T_OUT: begin
                    r_level <= r_q;
                    r_state <= T_IDLE;
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign o_busy  = r_state != T_IDLE;
    assign o_pos   = r_pos;
    assign o_level = r_level;

endmodule
